// ===== hdl/shabsh_pkg.sv =====
// shabsh_pkg: shared types, constants and round functions of the sha-256 byte stream hasher
// no dependencies; imported by every module of the block
`default_nettype none

package shabsh_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    typedef enum logic [1:0] {
        INS_MSG,
        INS_PAD80,
        INS_ZERO,
        INS_LEN
    } t_ins_sel;

    typedef struct packed {
        logic       insert;
        t_ins_sel   ins_sel;
        logic       count_inc;
        logic       load_vars;
        logic       round_en;
        logic [5:0] round_idx;
        logic       update_hash;
        logic       restart;
        logic [2:0] word_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic [5:0] fill;
    } t_dp_sts;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] FILL_LAST  = 6'd63;
    localparam logic [5:0] LEN_START  = 6'd56;
    localparam logic [5:0] ROUND_LAST = 6'd63;
    localparam logic [2:0] WORD_LAST  = 3'd7;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] sml_sigma0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sml_sigma1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                           input logic [31:0] g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/shabsh_dp.sv =====
// shabsh_dp: block shift register, message schedule, round logic, hash and byte count
// depends on shabsh_pkg; driven by shabsh_ctrl through t_dp_cmd
`default_nettype none

module shabsh_dp
    import shabsh_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_dp_cmd     i_cmd,
    input  wire logic [7:0]  i_data_byte,
    output t_dp_sts          o_sts,
    output logic [31:0]      o_digest_word
);

    logic [31:0]  r_hash [8];
    logic [31:0]  r_var  [8];
    logic [511:0] r_blk;
    logic [5:0]   r_fill;
    logic [60:0]  r_count;

    logic [511:0] n_blk;
    logic [31:0]  n_var [8];
    logic [7:0]   ins_byte;
    logic [7:0]   len_byte;
    logic [63:0]  bit_len;
    logic [2:0]   len_pos;
    logic [31:0]  w_cur;
    logic [31:0]  w_new;
    logic [31:0]  t1;
    logic [31:0]  t2;

    assign bit_len  = {r_count, 3'b000};
    assign len_pos  = WORD_LAST - r_fill[2:0];
    assign len_byte = bit_len[{len_pos, 3'b000} +: 8];

    always_comb begin
        unique case (i_cmd.ins_sel)
            INS_MSG:   ins_byte = i_data_byte;
            INS_PAD80: ins_byte = PAD_BYTE;
            INS_ZERO:  ins_byte = 8'h00;
            INS_LEN:   ins_byte = len_byte;
            default:   ins_byte = 8'h00;
        endcase
    end

    // word i of the window sits at r_blk[511-32*i -: 32]
    assign w_cur = r_blk[511:480];
    assign w_new = w_cur + sml_sigma0(r_blk[479:448]) + r_blk[223:192]
                 + sml_sigma1(r_blk[63:32]);

    assign t1 = r_var[7] + big_sigma1(r_var[4]) + choose(r_var[4], r_var[5], r_var[6])
              + ROUND_K[i_cmd.round_idx] + w_cur;
    assign t2 = big_sigma0(r_var[0]) + majority(r_var[0], r_var[1], r_var[2]);

    always_comb begin
        n_blk = r_blk;
        for (int i = 0; i < 8; i++) begin
            n_var[i] = r_var[i];
        end
        if (i_cmd.insert) begin
            n_blk = {r_blk[503:0], ins_byte};
        end else if (i_cmd.round_en) begin
            n_blk = {r_blk[479:0], w_new};
        end
        if (i_cmd.load_vars) begin
            for (int i = 0; i < 8; i++) begin
                n_var[i] = r_hash[i];
            end
        end else if (i_cmd.round_en) begin
            n_var[0] = t1 + t2;
            n_var[1] = r_var[0];
            n_var[2] = r_var[1];
            n_var[3] = r_var[2];
            n_var[4] = r_var[3] + t1;
            n_var[5] = r_var[4];
            n_var[6] = r_var[5];
            n_var[7] = r_var[6];
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk <= n_blk;
        for (int i = 0; i < 8; i++) begin
            r_var[i] <= n_var[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_hash[i] <= IV[i];
            end
            r_fill  <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.insert) begin
                r_fill <= r_fill + 6'd1;
            end
            if (i_cmd.restart) begin
                for (int i = 0; i < 8; i++) begin
                    r_hash[i] <= IV[i];
                end
                r_count <= '0;
            end else begin
                if (i_cmd.update_hash) begin
                    for (int i = 0; i < 8; i++) begin
                        r_hash[i] <= r_hash[i] + r_var[i];
                    end
                end
                if (i_cmd.count_inc) begin
                    r_count <= r_count + 61'd1;
                end
            end
        end
    end

    assign o_sts.fill    = r_fill;
    assign o_digest_word = r_hash[i_cmd.word_sel];

endmodule

`default_nettype wire

// ===== hdl/shabsh_ctrl.sv =====
// shabsh_ctrl: sequencer for byte loading, padding, compression rounds and digest readout
// depends on shabsh_pkg; commands shabsh_dp through t_dp_cmd
`default_nettype none

module shabsh_ctrl
    import shabsh_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_byte_present,
    input  wire logic    i_end_of_message,
    input  wire logic    i_out_ready,
    input  wire t_dp_sts i_sts,
    output logic         o_in_ready,
    output logic         o_out_valid,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMPRESS,
        ST_UPDATE,
        ST_PAD80,
        ST_PADZERO,
        ST_PADLEN,
        ST_OUTPUT
    } t_state;

    t_state     r_state, n_state;
    t_state     r_after, n_after;
    logic [5:0] r_round, n_round;
    logic [2:0] r_widx, n_widx;
    logic       block_full;

    assign block_full = (i_sts.fill == FILL_LAST);

    always_comb begin
        n_state = r_state;
        n_after = r_after;
        n_round = r_round;
        n_widx  = r_widx;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd.insert      = 1'b0;
        o_cmd.ins_sel     = INS_MSG;
        o_cmd.count_inc   = 1'b0;
        o_cmd.load_vars   = 1'b0;
        o_cmd.round_en    = 1'b0;
        o_cmd.round_idx   = r_round;
        o_cmd.update_hash = 1'b0;
        o_cmd.restart     = 1'b0;
        o_cmd.word_sel    = r_widx;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_byte_present) begin
                        o_cmd.insert    = 1'b1;
                        o_cmd.count_inc = 1'b1;
                    end
                    if (i_byte_present && block_full) begin
                        o_cmd.load_vars = 1'b1;
                        n_round = '0;
                        n_state = ST_COMPRESS;
                        n_after = i_end_of_message ? ST_PAD80 : ST_IDLE;
                    end else if (i_end_of_message) begin
                        n_state = ST_PAD80;
                    end
                end
            end
            ST_COMPRESS: begin
                o_cmd.round_en = 1'b1;
                n_round = r_round + 6'd1;
                if (r_round == ROUND_LAST) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                o_cmd.update_hash = 1'b1;
                n_state = r_after;
            end
            ST_PAD80: begin
                o_cmd.insert  = 1'b1;
                o_cmd.ins_sel = INS_PAD80;
                n_state = ST_PADZERO;
                if (block_full) begin
                    o_cmd.load_vars = 1'b1;
                    n_round = '0;
                    n_state = ST_COMPRESS;
                    n_after = ST_PADZERO;
                end
            end
            ST_PADZERO: begin
                if (i_sts.fill == LEN_START) begin
                    n_state = ST_PADLEN;
                end else begin
                    o_cmd.insert  = 1'b1;
                    o_cmd.ins_sel = INS_ZERO;
                    if (block_full) begin
                        o_cmd.load_vars = 1'b1;
                        n_round = '0;
                        n_state = ST_COMPRESS;
                        n_after = ST_PADZERO;
                    end
                end
            end
            ST_PADLEN: begin
                o_cmd.insert  = 1'b1;
                o_cmd.ins_sel = INS_LEN;
                if (block_full) begin
                    o_cmd.load_vars = 1'b1;
                    n_round = '0;
                    n_widx  = '0;
                    n_state = ST_COMPRESS;
                    n_after = ST_OUTPUT;
                end
            end
            ST_OUTPUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_widx = r_widx + 3'd1;
                    if (r_widx == WORD_LAST) begin
                        o_cmd.restart = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_after <= ST_IDLE;
            r_round <= '0;
            r_widx  <= '0;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
            r_round <= n_round;
            r_widx  <= n_widx;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sha256_byte_stream_hasher_core.sv =====
// after the 64th byte of a block: 64 rounds on the single round unit plus one hash update,
// during which no input is taken
// end of message: padding loads bytes into the block shift register, then one or two
// compressions, then eight digest word transfers, one per cycle while the receiver is ready
// reset: synchronous active low; initial hash and zero byte count, no clearing pass
`default_nettype none

module sha256_byte_stream_hasher_core
    import shabsh_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_item
);

    t_dp_cmd     cmd;
    t_dp_sts     sts;
    logic [31:0] digest_word;

    shabsh_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_byte_present   (i_in_item.byte_present),
        .i_end_of_message (i_in_item.end_of_message),
        .i_out_ready      (i_out_ready),
        .i_sts            (sts),
        .o_in_ready       (o_in_ready),
        .o_out_valid      (o_out_valid),
        .o_cmd            (cmd)
    );

    shabsh_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_data_byte   (i_in_item.data_byte),
        .o_sts         (sts),
        .o_digest_word (digest_word)
    );

    assign o_out_item.digest_word = digest_word;
    assign o_out_item.word_index  = cmd.word_sel;
    assign o_out_item.last_word   = (cmd.word_sel == WORD_LAST);

endmodule

`default_nettype wire

// ===== hdl/shabsh_chk.sv =====
// shabsh_chk: port-level checks of the hasher top level, bound to it below
// depends on shabsh_pkg and sha256_byte_stream_hasher_core
`default_nettype none

module shabsh_chk
    import shabsh_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_ready,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out_item
);

    // input is never taken while the digest is being read out
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready during digest readout");

    // stalled digest word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("digest word changed while stalled");

    // words follow in order without gaps
    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_item.last_word |=>
            o_out_valid && o_out_item.word_index == $past(o_out_item.word_index) + 3'd1)
        else $error("digest word order broken");

    // last flag only on the eighth word, then back to accepting input
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.last_word == (o_out_item.word_index == WORD_LAST))
        else $error("last flag mismatch");

    a_back_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out_item.last_word |=> o_in_ready && !o_out_valid)
        else $error("not idle after digest transfer");

endmodule

bind sha256_byte_stream_hasher_core shabsh_chk u_shabsh_chk (.*);

`default_nettype wire

// ===== tb/sha256_byte_stream_hasher_core_tb.sv =====
// sha256_byte_stream_hasher_core_tb: self-checking bench for the sha-256 byte stream hasher
// needs shabsh_pkg (item structs) and sha256_byte_stream_hasher_core; predicts each digest
// with its own sha-256 and checks every digest word transfer against it
module sha256_byte_stream_hasher_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import shabsh_pkg::t_in_item;
    import shabsh_pkg::t_out_item;

    localparam int RDY_FREE  = 0;
    localparam int RDY_COIN  = 1;
    localparam int RDY_THIRD = 2;

    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AFTER_MSG = 4;
    localparam int DRAIN_CYCLES   = 250;
    localparam int STIM_TARGET    = 170;

    localparam bit [31:0] HASH_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam bit [31:0] ROUND_CONST [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    t_in_item  pending_items [$];
    t_out_item digest_words_due [$];

    bit [31:0] chain_h [8] = HASH_INIT;
    bit [7:0]  block_bytes [64];
    bit [60:0] msg_bytes = '0;

    bit in_taken = 1'b0;
    int fail_count = 0;
    int messages_closed = 0;
    int stim_count = 0;

    int gap_left = 0;
    int burst_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int stall_mode = RDY_FREE;
    int mode_left = 0;

    sha256_byte_stream_hasher_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit [31:0] ror32(bit [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void compress_chunk();
        bit [31:0] w [64];
        bit [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int i = 0; i < 16; i++) begin
            w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
        end
        for (int i = 16; i < 64; i++) begin
            w[i] = w[i-16] + w[i-7]
                 + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
        end
        a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
        e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
        for (int i = 0; i < 64; i++) begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
               + ROUND_CONST[i] + w[i];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
        chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
    endfunction

    function automatic void absorb_item(t_in_item it);
        bit [5:0]  pos;
        bit [63:0] bit_len;
        t_out_item word;
        if (it.byte_present) begin
            pos = msg_bytes[5:0];
            block_bytes[pos] = it.data_byte;
            msg_bytes = msg_bytes + 1'b1;
            if (pos == 6'd63) compress_chunk();
        end
        if (it.end_of_message) begin
            pos = msg_bytes[5:0];
            block_bytes[pos] = 8'h80;
            for (int k = int'(pos) + 1; k < 64; k++) block_bytes[k] = 8'h00;
            if (pos >= 6'd56) begin
                compress_chunk();
                for (int k = 0; k < 64; k++) block_bytes[k] = 8'h00;
            end
            bit_len = {msg_bytes, 3'b000};
            for (int k = 0; k < 8; k++) block_bytes[63-k] = bit_len[8*k +: 8];
            compress_chunk();
            for (int k = 0; k < 8; k++) begin
                word.digest_word = chain_h[k];
                word.word_index  = 3'(k);
                word.last_word   = (k == 7);
                digest_words_due.push_back(word);
            end
            chain_h = HASH_INIT;
            msg_bytes = '0;
        end
    endfunction

    task automatic push_item(bit [7:0] data, bit present, bit last);
        t_in_item it;
        it.data_byte = data;
        it.byte_present = present;
        it.end_of_message = last;
        pending_items.push_back(it);
        if (present || last) stim_count++;
    endtask

    // random content, idle items sprinkled in, end flag on the last byte or on its own
    task automatic queue_message(int len, bit separate_end);
        for (int n = 0; n < len; n++) begin
            if ($urandom_range(0, 9) == 0) push_item(8'($urandom), 1'b0, 1'b0);
            push_item(8'($urandom), 1'b1, (n == len - 1) && !separate_end);
        end
        if (len == 0 || separate_end) push_item(8'($urandom), 1'b0, 1'b1);
    endtask

    // driver: bursts of transfers with random gaps
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                i_in_valid <= 1'b1;
                i_in_item <= pending_items.pop_front();
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 40);
                    gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30)
                                                           : $urandom_range(1, 5);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: stall modes that change at random, plus one long hold-off
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (!hold_done && messages_closed >= HOLD_AFTER_MSG) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            if (mode_left > 0) begin
                mode_left--;
            end else begin
                stall_mode = $urandom_range(RDY_FREE, RDY_THIRD);
                mode_left = $urandom_range(8, 48);
            end
            case (stall_mode)
                RDY_FREE: i_out_ready <= 1'b1;
                RDY_COIN: i_out_ready <= 1'($urandom_range(0, 1));
                default:  i_out_ready <= (mode_left % 3 == 0);
            endcase
        end
    end

    // monitor: predict on each input transfer, check each digest word transfer
    always @(posedge i_clk) begin
        t_out_item want;
        in_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            absorb_item(i_in_item);
            if (i_in_item.end_of_message) messages_closed++;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (digest_words_due.size() == 0) begin
                $error("digest word transfer with nothing expected: %h", o_out_item);
                fail_count++;
            end else begin
                want = digest_words_due.pop_front();
                if (o_out_item.digest_word !== want.digest_word) begin
                    $error("digest_word mismatch: expected %h, actual %h",
                           want.digest_word, o_out_item.digest_word);
                    fail_count++;
                end
                if (o_out_item.word_index !== want.word_index) begin
                    $error("word_index mismatch: expected %0d, actual %0d",
                           want.word_index, o_out_item.word_index);
                    fail_count++;
                end
                if (o_out_item.last_word !== want.last_word) begin
                    $error("last_word mismatch: expected %b, actual %b",
                           want.last_word, o_out_item.last_word);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int msg_idx;
        int len_a;
        int len_b;

        // directed: idle item, back-to-back empty messages, "abc" with an idle item inside,
        // extreme bytes, end mark on its own after bytes
        push_item(8'hff, 1'b0, 1'b0);
        push_item(8'h3c, 1'b0, 1'b1);
        push_item(8'h00, 1'b0, 1'b1);
        push_item(8'h61, 1'b1, 1'b0);
        push_item(8'h5a, 1'b0, 1'b0);
        push_item(8'h62, 1'b1, 1'b0);
        push_item(8'h63, 1'b1, 1'b1);
        push_item(8'h00, 1'b1, 1'b1);
        push_item(8'hff, 1'b1, 1'b0);
        push_item(8'h80, 1'b1, 1'b0);
        push_item(8'hff, 1'b0, 1'b1);
        push_item(8'hff, 1'b1, 1'b1);

        // random messages; one lands on the one/two padding block edge, one on the full block edge
        len_a = $urandom_range(0, 1) ? 55 : 56;
        len_b = $urandom_range(0, 1) ? 63 : 64;
        msg_idx = 0;
        while (stim_count < STIM_TARGET) begin
            if (msg_idx == 2) queue_message(len_a, 1'($urandom_range(0, 1)));
            else if (msg_idx == 6) queue_message(len_b, 1'($urandom_range(0, 1)));
            else queue_message($urandom_range(0, 12), 1'($urandom_range(0, 2) == 0));
            msg_idx++;
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || i_in_valid || digest_words_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/shabsh_pkg.sv
hdl/shabsh_dp.sv
hdl/shabsh_ctrl.sv
hdl/sha256_byte_stream_hasher_core.sv
hdl/shabsh_chk.sv
tb/sha256_byte_stream_hasher_core_tb.sv
